@@ rtl/ptis_pkg.sv @@
package ptis_pkg;

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_LOAD   = 3'd1;
    localparam logic [2:0] CMD_PREP   = 3'd2;
    localparam logic [2:0] CMD_QUERY  = 3'd3;
    localparam logic [2:0] CMD_SAMPLE = 3'd4;

    localparam logic [2:0] STAT_OK     = 3'd0;
    localparam logic [2:0] STAT_FULL   = 3'd1;
    localparam logic [2:0] STAT_BAD    = 3'd2;
    localparam logic [2:0] STAT_UNPREP = 3'd3;
    localparam logic [2:0] STAT_ZERO   = 3'd4;

    localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;
    localparam logic signed [31:0] NEG_ONE_Q30 = 32'shC000_0000;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHK_RD,
        S_CHK_EV,
        S_SUM_RD,
        S_SUM_EV,
        S_SUM_MS,
        S_SUM_MW,
        S_CUM0,
        S_CUM_DS,
        S_CUM_DW,
        S_NRM_RD,
        S_NRM_EV,
        S_NRM_DS,
        S_NRM_DW,
        S_Q_RD,
        S_Q_EV,
        S_Q_DS,
        S_Q_DW,
        S_Q_MS,
        S_Q_MW,
        S_OUT
    } state_t;

endpackage

@@ rtl/ptis_div.sv @@
module ptis_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    input  logic               shift32,
    output logic               done,
    output logic signed [31:0] quot
);

    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    logic [95:0] dvd_reg;
    logic [63:0] rem_reg;
    logic [33:0] q_reg;
    logic        sat_reg;
    logic        neg_reg;
    logic [63:0] ud_reg;

    logic [63:0] un;
    logic [63:0] ud;
    logic [64:0] rem_sh;
    logic        ge;
    logic [33:0] q_next;

    assign un     = num[63] ? (64'd0 - num) : num;
    assign ud     = den[63] ? (64'd0 - den) : den;
    assign rem_sh = {rem_reg, dvd_reg[95]};
    assign ge     = rem_sh >= {1'b0, ud_reg};
    assign q_next = {q_reg[32:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd95;
                dvd_reg  <= shift32 ? {un, 32'd0} : {2'd0, un, 30'd0};
                rem_reg  <= '0;
                q_reg    <= '0;
                sat_reg  <= 1'b0;
                neg_reg  <= num[63] ^ den[63];
                ud_reg   <= ud;
            end else if (busy_reg) begin
                rem_reg <= ge ? 64'(rem_sh - {1'b0, ud_reg}) : rem_sh[63:0];
                q_reg   <= q_next;
                sat_reg <= sat_reg | (q_next > 34'h0_8000_0000);
                dvd_reg <= {dvd_reg[94:0], 1'b0};
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;

    always_comb begin
        if (neg_reg) begin
            quot = sat_reg ? 32'sh8000_0000 : (32'd0 - q_reg[31:0]);
        end else begin
            quot = (sat_reg || q_reg[31]) ? 32'sh7FFF_FFFF : q_reg[31:0];
        end
    end

endmodule

@@ rtl/ptis_mul.sv @@
module ptis_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic               done,
    output logic signed [65:0] prod
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [33:0] hi_reg;
    logic [32:0] lo_reg;
    logic [32:0] mc_reg;
    logic        neg_reg;

    logic [32:0] ua;
    logic [32:0] ub;
    logic [33:0] sum;
    logic [65:0] mag;

    assign ua  = a[32] ? (33'd0 - a) : a;
    assign ub  = b[32] ? (33'd0 - b) : b;
    assign sum = hi_reg + (lo_reg[0] ? {1'b0, mc_reg} : 34'd0);
    assign mag = {hi_reg[32:0], lo_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
                hi_reg   <= '0;
                lo_reg   <= ub;
                mc_reg   <= ua;
                neg_reg  <= a[32] ^ b[32];
            end else if (busy_reg) begin
                hi_reg  <= {1'b0, sum[33:1]};
                lo_reg  <= {sum[0], lo_reg[32:1]};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = neg_reg ? (66'd0 - mag) : mag;

endmodule

@@ rtl/phase_table_interp_sampler.sv @@
// Uses one shared 96-step bit-serial divider and one shared 33-step serial multiplier.
// Throughput: one transaction at a time; input is taken only when no result is pending.
// Reset: entry count and prepared flag clear; table memories are not initialized.
module phase_table_interp_sampler #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cos_value, raw_first, raw_second, raw_third, raw_fourth, uniform
    input  logic [191:0] s_axis_tdata,
    // command
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_p1, out_p2, out_p3, out_p4, out_cos
    output logic [159:0] m_axis_tdata,
    // status
    output logic [2:0]   m_axis_tuser
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    ptis_pkg::state_t state_reg, state_next;

    logic [CW-1:0]      cnt_reg;
    logic               prep_reg;
    logic [AW-1:0]      idx_reg;
    logic [1:0]         j_reg;
    logic               pass2_reg;
    logic [2:0]         cmd_reg;
    logic signed [31:0] c_reg;
    logic signed [31:0] t_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] tot_reg;
    logic signed [31:0] w_reg;
    logic signed [31:0] cur_cos_reg, prev_cos_reg, cur_cum_reg, prev_cum_reg;
    logic signed [31:0] cur_e_reg [4];
    logic signed [31:0] prev_e_reg [4];
    logic signed [31:0] res_p_reg [4];
    logic signed [31:0] res_cos_reg;
    logic [2:0]         status_reg;

    logic [31:0] cos_mem [MAX_ENTRIES];
    logic [31:0] cum_mem [MAX_ENTRIES];
    logic [31:0] elem_mem [4][MAX_ENTRIES];
    logic signed [31:0] rd_cos, rd_cum;
    logic signed [31:0] rd_e [4];

    logic        accept_in;
    logic [2:0]  cmd_in;
    logic        is_sample;
    logic        idx_last;
    logic        idx_zero;
    logic        full;
    logic        hit;
    logic        chk_bad;
    logic        we_ld;
    logic        we_cum;
    logic [3:0]  elem_we;
    logic [AW-1:0] wa;
    logic signed [31:0] cum_wd;
    logic signed [31:0] elem_wd [4];
    logic signed [32:0] ld_sum, ld_dif;

    logic               mul_start, mul_done;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_prod;
    logic               div_start, div_done, div_s32;
    logic signed [63:0] div_num, div_den;
    logic signed [31:0] div_q;

    logic signed [63:0] term;
    logic signed [63:0] acc_sum;
    logic signed [31:0] lerp_base;
    logic signed [31:0] lerp_res;
    logic signed [32:0] q_num33, q_den33;

    assign cmd_in    = s_axis_tuser;
    assign accept_in = s_axis_tvalid && s_axis_tready;
    assign is_sample = (cmd_reg == ptis_pkg::CMD_SAMPLE);
    assign idx_last  = (CW'(idx_reg) == (cnt_reg - CW'(1)));
    assign idx_zero  = (idx_reg == '0);
    assign full      = (cnt_reg == CW'(MAX_ENTRIES));

    assign hit = is_sample ? (rd_cum >= t_reg) : (rd_cos <= c_reg);
    assign chk_bad = (idx_zero && rd_cos != ptis_pkg::ONE_Q30)
                  || (!idx_zero && rd_cos > cur_cos_reg)
                  || (idx_last && rd_cos != ptis_pkg::NEG_ONE_Q30);

    assign ld_sum = {s_axis_tdata[63], s_axis_tdata[63:32]}
                  + {s_axis_tdata[95], s_axis_tdata[95:64]};
    assign ld_dif = {s_axis_tdata[63], s_axis_tdata[63:32]}
                  - {s_axis_tdata[95], s_axis_tdata[95:64]};

    assign wa = (state_reg == ptis_pkg::S_IDLE) ? cnt_reg[AW-1:0] : idx_reg;

    always_comb begin
        elem_wd[0] = we_ld ? ld_sum[32:1] : div_q;
        elem_wd[1] = we_ld ? ld_dif[32:1] : div_q;
        elem_wd[2] = we_ld ? s_axis_tdata[127:96] : div_q;
        elem_wd[3] = we_ld ? s_axis_tdata[159:128] : div_q;
    end

    always_ff @(posedge aclk) begin
        if (we_ld) begin
            cos_mem[wa] <= s_axis_tdata[31:0];
        end
        if (we_cum) begin
            cum_mem[wa] <= cum_wd;
        end
        for (int k = 0; k < 4; k++) begin
            if (elem_we[k]) begin
                elem_mem[k][wa] <= elem_wd[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_cos <= cos_mem[idx_reg];
        rd_cum <= cum_mem[idx_reg];
        for (int k = 0; k < 4; k++) begin
            rd_e[k] <= elem_mem[k][idx_reg];
        end
    end

    assign term    = {{14{mul_prod[65]}}, mul_prod[65:16]};
    assign acc_sum = acc_reg + term;

    assign q_num33 = is_sample ? ({t_reg[31], t_reg} - {prev_cum_reg[31], prev_cum_reg})
                               : ({c_reg[31], c_reg} - {cur_cos_reg[31], cur_cos_reg});
    assign q_den33 = is_sample ? ({cur_cum_reg[31], cur_cum_reg}
                                  - {prev_cum_reg[31], prev_cum_reg})
                               : ({prev_cos_reg[31], prev_cos_reg}
                                  - {cur_cos_reg[31], cur_cos_reg});

    always_comb begin
        div_num = {{31{q_num33[32]}}, q_num33};
        div_den = {{31{q_den33[32]}}, q_den33};
        div_s32 = 1'b0;
        case (state_reg)
            ptis_pkg::S_CUM_DS: begin
                div_num = acc_reg;
                div_den = tot_reg;
            end
            ptis_pkg::S_NRM_DS: begin
                div_num = {{32{cur_e_reg[j_reg][31]}}, cur_e_reg[j_reg]};
                div_den = tot_reg;
                div_s32 = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (state_reg == ptis_pkg::S_SUM_MS) begin
            mul_a = {prev_cos_reg[31], prev_cos_reg} - {cur_cos_reg[31], cur_cos_reg};
            mul_b = {prev_e_reg[0][31], prev_e_reg[0]} + {cur_e_reg[0][31], cur_e_reg[0]};
        end else if (is_sample) begin
            mul_a = {cur_cos_reg[31], cur_cos_reg} - {prev_cos_reg[31], prev_cos_reg};
            mul_b = {w_reg[31], w_reg};
        end else begin
            mul_a = {prev_e_reg[j_reg][31], prev_e_reg[j_reg]}
                  - {cur_e_reg[j_reg][31], cur_e_reg[j_reg]};
            mul_b = {w_reg[31], w_reg};
        end
    end

    assign lerp_base = is_sample ? prev_cos_reg : cur_e_reg[j_reg];
    assign lerp_res  = lerp_base + mul_prod[61:30];

    ptis_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    ptis_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .shift32 (div_s32),
        .done    (div_done),
        .quot    (div_q)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ptis_pkg::S_IDLE: begin
                if (accept_in) begin
                    case (cmd_in)
                        ptis_pkg::CMD_PREP: begin
                            state_next = (cnt_reg < CW'(2)) ? ptis_pkg::S_OUT
                                                            : ptis_pkg::S_CHK_RD;
                        end
                        ptis_pkg::CMD_QUERY, ptis_pkg::CMD_SAMPLE: begin
                            state_next = prep_reg ? ptis_pkg::S_Q_RD : ptis_pkg::S_OUT;
                        end
                        default: state_next = ptis_pkg::S_OUT;
                    endcase
                end
            end
            ptis_pkg::S_CHK_RD: state_next = ptis_pkg::S_CHK_EV;
            ptis_pkg::S_CHK_EV: begin
                if (chk_bad) begin
                    state_next = ptis_pkg::S_OUT;
                end else if (idx_last) begin
                    state_next = ptis_pkg::S_SUM_RD;
                end else begin
                    state_next = ptis_pkg::S_CHK_RD;
                end
            end
            ptis_pkg::S_SUM_RD: state_next = ptis_pkg::S_SUM_EV;
            ptis_pkg::S_SUM_EV: begin
                state_next = idx_zero ? ptis_pkg::S_SUM_RD : ptis_pkg::S_SUM_MS;
            end
            ptis_pkg::S_SUM_MS: state_next = ptis_pkg::S_SUM_MW;
            ptis_pkg::S_SUM_MW: begin
                if (mul_done) begin
                    if (pass2_reg) begin
                        state_next = ptis_pkg::S_CUM_DS;
                    end else if (idx_last) begin
                        state_next = (acc_sum == 64'sd0) ? ptis_pkg::S_OUT
                                                         : ptis_pkg::S_CUM0;
                    end else begin
                        state_next = ptis_pkg::S_SUM_RD;
                    end
                end
            end
            ptis_pkg::S_CUM0:   state_next = ptis_pkg::S_SUM_RD;
            ptis_pkg::S_CUM_DS: state_next = ptis_pkg::S_CUM_DW;
            ptis_pkg::S_CUM_DW: begin
                if (div_done) begin
                    state_next = idx_last ? ptis_pkg::S_NRM_RD : ptis_pkg::S_SUM_RD;
                end
            end
            ptis_pkg::S_NRM_RD: state_next = ptis_pkg::S_NRM_EV;
            ptis_pkg::S_NRM_EV: state_next = ptis_pkg::S_NRM_DS;
            ptis_pkg::S_NRM_DS: state_next = ptis_pkg::S_NRM_DW;
            ptis_pkg::S_NRM_DW: begin
                if (div_done) begin
                    if (j_reg == 2'd3) begin
                        state_next = idx_last ? ptis_pkg::S_OUT : ptis_pkg::S_NRM_RD;
                    end else begin
                        state_next = ptis_pkg::S_NRM_DS;
                    end
                end
            end
            ptis_pkg::S_Q_RD: state_next = ptis_pkg::S_Q_EV;
            ptis_pkg::S_Q_EV: begin
                if (hit) begin
                    state_next = idx_zero ? ptis_pkg::S_OUT : ptis_pkg::S_Q_DS;
                end else begin
                    state_next = idx_last ? ptis_pkg::S_OUT : ptis_pkg::S_Q_RD;
                end
            end
            ptis_pkg::S_Q_DS: state_next = ptis_pkg::S_Q_DW;
            ptis_pkg::S_Q_DW: begin
                if (div_done) begin
                    state_next = ptis_pkg::S_Q_MS;
                end
            end
            ptis_pkg::S_Q_MS: state_next = ptis_pkg::S_Q_MW;
            ptis_pkg::S_Q_MW: begin
                if (mul_done) begin
                    state_next = (is_sample || j_reg == 2'd3) ? ptis_pkg::S_OUT
                                                              : ptis_pkg::S_Q_MS;
                end
            end
            ptis_pkg::S_OUT: begin
                if (m_axis_tready) begin
                    state_next = ptis_pkg::S_IDLE;
                end
            end
            default: state_next = ptis_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (state_reg == ptis_pkg::S_IDLE);
        m_axis_tvalid = (state_reg == ptis_pkg::S_OUT);
        we_ld         = accept_in && (cmd_in == ptis_pkg::CMD_LOAD) && !full;
        we_cum        = (state_reg == ptis_pkg::S_CUM0)
                     || ((state_reg == ptis_pkg::S_CUM_DW) && div_done);
        cum_wd        = (state_reg == ptis_pkg::S_CUM0) ? 32'sd0 : div_q;
        mul_start     = (state_reg == ptis_pkg::S_SUM_MS) || (state_reg == ptis_pkg::S_Q_MS);
        div_start     = (state_reg == ptis_pkg::S_CUM_DS) || (state_reg == ptis_pkg::S_NRM_DS)
                     || (state_reg == ptis_pkg::S_Q_DS);
        for (int k = 0; k < 4; k++) begin
            elem_we[k] = we_ld || ((state_reg == ptis_pkg::S_NRM_DW) && div_done
                                   && (j_reg == 2'(k)));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ptis_pkg::S_IDLE;
            cnt_reg   <= '0;
            prep_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept_in) begin
                case (cmd_in)
                    ptis_pkg::CMD_CLEAR: begin
                        cnt_reg  <= '0;
                        prep_reg <= 1'b0;
                    end
                    ptis_pkg::CMD_LOAD: begin
                        prep_reg <= 1'b0;
                        if (!full) begin
                            cnt_reg <= cnt_reg + CW'(1);
                        end
                    end
                    ptis_pkg::CMD_PREP: prep_reg <= 1'b0;
                    default: begin
                    end
                endcase
            end
            if (state_reg == ptis_pkg::S_NRM_DW && div_done && j_reg == 2'd3 && idx_last) begin
                prep_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_in) begin
            cmd_reg     <= cmd_in;
            c_reg       <= s_axis_tdata[31:0];
            t_reg       <= ptis_pkg::ONE_Q30 - {2'b00, s_axis_tdata[191:162]};
            idx_reg     <= '0;
            j_reg       <= '0;
            res_cos_reg <= '0;
            for (int k = 0; k < 4; k++) begin
                res_p_reg[k] <= '0;
            end
            case (cmd_in)
                ptis_pkg::CMD_LOAD: begin
                    status_reg <= full ? ptis_pkg::STAT_FULL : ptis_pkg::STAT_OK;
                end
                ptis_pkg::CMD_PREP: begin
                    status_reg <= (cnt_reg < CW'(2)) ? ptis_pkg::STAT_BAD : ptis_pkg::STAT_OK;
                end
                ptis_pkg::CMD_QUERY, ptis_pkg::CMD_SAMPLE: begin
                    status_reg <= prep_reg ? ptis_pkg::STAT_OK : ptis_pkg::STAT_UNPREP;
                end
                default: begin
                    status_reg <= ptis_pkg::STAT_OK;
                end
            endcase
        end

        if (state_reg == ptis_pkg::S_CHK_EV || state_reg == ptis_pkg::S_SUM_EV
            || state_reg == ptis_pkg::S_NRM_EV || state_reg == ptis_pkg::S_Q_EV) begin
            cur_cos_reg  <= rd_cos;
            prev_cos_reg <= cur_cos_reg;
            cur_cum_reg  <= rd_cum;
            prev_cum_reg <= cur_cum_reg;
            for (int k = 0; k < 4; k++) begin
                cur_e_reg[k]  <= rd_e[k];
                prev_e_reg[k] <= cur_e_reg[k];
            end
        end

        case (state_reg)
            ptis_pkg::S_CHK_EV: begin
                if (chk_bad) begin
                    status_reg <= ptis_pkg::STAT_BAD;
                end else if (idx_last) begin
                    idx_reg   <= '0;
                    acc_reg   <= '0;
                    pass2_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + AW'(1);
                end
            end
            ptis_pkg::S_SUM_EV: begin
                if (idx_zero) begin
                    idx_reg <= AW'(1);
                end
            end
            ptis_pkg::S_SUM_MW: begin
                if (mul_done) begin
                    if (!pass2_reg && idx_last) begin
                        tot_reg   <= acc_sum;
                        acc_reg   <= '0;
                        pass2_reg <= 1'b1;
                        idx_reg   <= '0;
                        if (acc_sum == 64'sd0) begin
                            status_reg <= ptis_pkg::STAT_ZERO;
                        end
                    end else begin
                        acc_reg <= acc_sum;
                        if (!pass2_reg) begin
                            idx_reg <= idx_reg + AW'(1);
                        end
                    end
                end
            end
            ptis_pkg::S_CUM_DW: begin
                if (div_done) begin
                    idx_reg <= idx_last ? '0 : (idx_reg + AW'(1));
                end
            end
            ptis_pkg::S_NRM_DW: begin
                if (div_done) begin
                    j_reg <= j_reg + 2'd1;
                    if (j_reg == 2'd3 && !idx_last) begin
                        idx_reg <= idx_reg + AW'(1);
                    end
                end
            end
            ptis_pkg::S_Q_EV: begin
                if ((hit && idx_zero) || (!hit && idx_last)) begin
                    if (is_sample) begin
                        res_cos_reg <= hit ? ptis_pkg::ONE_Q30 : ptis_pkg::NEG_ONE_Q30;
                    end else begin
                        for (int k = 0; k < 4; k++) begin
                            res_p_reg[k] <= rd_e[k];
                        end
                    end
                end else if (!hit) begin
                    idx_reg <= idx_reg + AW'(1);
                end
            end
            ptis_pkg::S_Q_DW: begin
                if (div_done) begin
                    w_reg <= div_q;
                    j_reg <= '0;
                end
            end
            ptis_pkg::S_Q_MW: begin
                if (mul_done) begin
                    if (is_sample) begin
                        res_cos_reg <= lerp_res;
                    end else begin
                        res_p_reg[j_reg] <= lerp_res;
                        j_reg            <= j_reg + 2'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tdata = {res_cos_reg, res_p_reg[3], res_p_reg[2], res_p_reg[1], res_p_reg[0]};
    assign m_axis_tuser = status_reg;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int  TBL_DEPTH   = 256;
    localparam int  CYCLE_LIMIT = 20000000;
    localparam int  RAND_ITEMS  = 500;
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] p3;
        logic [31:0] p4;
        logic [31:0] cosv;
        logic [2:0]  status;
    } scatter_result_t;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    phase_table_interp_sampler uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    int tbl_cos [TBL_DEPTH];
    int tbl_e1 [TBL_DEPTH];
    int tbl_e2 [TBL_DEPTH];
    int tbl_e3 [TBL_DEPTH];
    int tbl_e4 [TBL_DEPTH];
    int tbl_cum [TBL_DEPTH];
    int tbl_count;
    bit tbl_ready;

    scatter_result_t pending_results[$];
    int  err_count;
    int  items_sent;
    int  cycles = 0;
    bit  no_idle;

    initial begin
        aclk = 1'b0;
    end

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic int sat_div(longint num, longint den, int shift);
        longint unsigned lim;
        longint unsigned un;
        longint unsigned ud;
        longint unsigned q;
        longint unsigned r;
        bit neg;
        bit sat;
        int k;
        lim = 64'd2147483648;
        neg = (num < 0) != (den < 0);
        un = (num < 0) ? longint'(-num) : longint'(num);
        ud = (den < 0) ? longint'(-den) : longint'(den);
        q = un / ud;
        r = un % ud;
        sat = q > lim;
        for (k = 0; k < shift && !sat; k++) begin
            q = q << 1;
            r = r << 1;
            if (r >= ud) begin
                r = r - ud;
                q = q + 1;
            end
            if (q > lim) sat = 1'b1;
        end
        if (neg) return sat ? 32'sh8000_0000 : int'(-longint'(q));
        if (sat || q >= lim) return 32'sh7fff_ffff;
        return int'(q);
    endfunction

    function automatic int lerp32(int base, int other, longint w);
        longint d;
        d = longint'(other) - longint'(base);
        return int'(longint'(base) + ((d * w) >>> 30));
    endfunction

    function automatic longint interval_area(int i);
        longint d;
        longint s;
        d = longint'(tbl_cos[i]) - longint'(tbl_cos[i + 1]);
        s = longint'(tbl_e1[i]) + longint'(tbl_e1[i + 1]);
        return (d * s) >>> 16;
    endfunction

    function automatic logic [2:0] prepare_table();
        longint total;
        longint part;
        int i;
        total = 0;
        part = 0;
        tbl_ready = 1'b0;
        if (tbl_count < 2 || tbl_cos[0] != ptis_pkg::ONE_Q30
            || tbl_cos[tbl_count - 1] != ptis_pkg::NEG_ONE_Q30)
            return ptis_pkg::STAT_BAD;
        for (i = 0; i + 1 < tbl_count; i++)
            if (tbl_cos[i + 1] > tbl_cos[i]) return ptis_pkg::STAT_BAD;
        for (i = 0; i + 1 < tbl_count; i++) total += interval_area(i);
        if (total == 0) return ptis_pkg::STAT_ZERO;
        tbl_cum[0] = 0;
        for (i = 0; i + 1 < tbl_count; i++) begin
            part += interval_area(i);
            tbl_cum[i + 1] = sat_div(part, total, 30);
        end
        for (i = 0; i < tbl_count; i++) begin
            tbl_e1[i] = sat_div(tbl_e1[i], total, 32);
            tbl_e2[i] = sat_div(tbl_e2[i], total, 32);
            tbl_e3[i] = sat_div(tbl_e3[i], total, 32);
            tbl_e4[i] = sat_div(tbl_e4[i], total, 32);
        end
        tbl_ready = 1'b1;
        return ptis_pkg::STAT_OK;
    endfunction

    function automatic scatter_result_t predict_scatter(logic [2:0] cmd, logic [191:0] d);
        scatter_result_t res;
        int c;
        int i;
        int j;
        longint w;
        longint t;
        longint lo;
        longint a;
        longint b;
        res = '0;
        c = int'(d[31:0]);
        case (cmd)
            ptis_pkg::CMD_CLEAR: begin
                tbl_count = 0;
                tbl_ready = 1'b0;
            end
            ptis_pkg::CMD_LOAD: begin
                tbl_ready = 1'b0;
                if (tbl_count >= TBL_DEPTH) begin
                    res.status = ptis_pkg::STAT_FULL;
                end else begin
                    a = longint'(int'(d[63:32]));
                    b = longint'(int'(d[95:64]));
                    tbl_cos[tbl_count] = c;
                    tbl_e1[tbl_count] = int'((a + b) >>> 1);
                    tbl_e2[tbl_count] = int'((a - b) >>> 1);
                    tbl_e3[tbl_count] = int'(d[127:96]);
                    tbl_e4[tbl_count] = int'(d[159:128]);
                    tbl_count++;
                end
            end
            ptis_pkg::CMD_PREP: res.status = prepare_table();
            ptis_pkg::CMD_QUERY: begin
                if (!tbl_ready) begin
                    res.status = ptis_pkg::STAT_UNPREP;
                end else begin
                    i = 0;
                    while (i < tbl_count && tbl_cos[i] > c) i++;
                    if (i == 0 || i >= tbl_count) begin
                        j = (i == 0) ? 0 : tbl_count - 1;
                        res.p1 = tbl_e1[j];
                        res.p2 = tbl_e2[j];
                        res.p3 = tbl_e3[j];
                        res.p4 = tbl_e4[j];
                    end else begin
                        w = sat_div(longint'(c) - tbl_cos[i],
                                    longint'(tbl_cos[i - 1]) - tbl_cos[i], 30);
                        res.p1 = lerp32(tbl_e1[i], tbl_e1[i - 1], w);
                        res.p2 = lerp32(tbl_e2[i], tbl_e2[i - 1], w);
                        res.p3 = lerp32(tbl_e3[i], tbl_e3[i - 1], w);
                        res.p4 = lerp32(tbl_e4[i], tbl_e4[i - 1], w);
                    end
                end
            end
            ptis_pkg::CMD_SAMPLE: begin
                if (!tbl_ready) begin
                    res.status = ptis_pkg::STAT_UNPREP;
                end else begin
                    t = longint'(ptis_pkg::ONE_Q30) - longint'({34'd0, d[191:162]});
                    i = 0;
                    while (i < tbl_count && tbl_cum[i] < t) i++;
                    if (i == 0) res.cosv = ptis_pkg::ONE_Q30;
                    else if (i >= tbl_count) res.cosv = ptis_pkg::NEG_ONE_Q30;
                    else begin
                        lo = tbl_cum[i - 1];
                        w = sat_div(t - lo, longint'(tbl_cum[i]) - lo, 30);
                        res.cosv = lerp32(tbl_cos[i - 1], tbl_cos[i], w);
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    task automatic send_item(logic [2:0] cmd, logic [31:0] cosv, logic [31:0] r1,
                             logic [31:0] r2, logic [31:0] r3, logic [31:0] r4,
                             logic [31:0] u);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata = {u, r4, r3, r2, r1, cosv};
        s_axis_tuser = cmd;
        s_axis_tvalid = 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        pending_results = {pending_results, predict_scatter(cmd, s_axis_tdata)};
        items_sent++;
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic load_entry(logic [31:0] cosv, logic [31:0] r1, logic [31:0] r2,
                              logic [31:0] r3, logic [31:0] r4);
        send_item(ptis_pkg::CMD_LOAD, cosv, r1, r2, r3, r4, $urandom);
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0) @(negedge aclk);
        s_axis_tvalid = 1'b0;
    endtask

    initial begin
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            m_axis_tready = 1'b0;
            repeat (stall) @(negedge aclk);
            m_axis_tready = 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            if (pending_results.size() == 0) begin
                $display("unexpected transaction at %0t", $realtime);
                err_count++;
            end else begin
                scatter_result_t want;
                want = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== want.p1)
                    report_mismatch("out_p1", m_axis_tdata[31:0], want.p1);
                if (m_axis_tdata[63:32] !== want.p2)
                    report_mismatch("out_p2", m_axis_tdata[63:32], want.p2);
                if (m_axis_tdata[95:64] !== want.p3)
                    report_mismatch("out_p3", m_axis_tdata[95:64], want.p3);
                if (m_axis_tdata[127:96] !== want.p4)
                    report_mismatch("out_p4", m_axis_tdata[127:96], want.p4);
                if (m_axis_tdata[159:128] !== want.cosv)
                    report_mismatch("out_cos", m_axis_tdata[159:128], want.cosv);
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", {29'd0, m_axis_tuser}, {29'd0, want.status});
            end
            @(negedge aclk);
        end
    end

    task automatic test_directed();
        no_idle = 1'b0;
        send_item(ptis_pkg::CMD_QUERY, 32'd0, '0, '0, '0, '0, '0);
        send_item(ptis_pkg::CMD_SAMPLE, 32'd0, '0, '0, '0, '0, 32'h8000_0000);
        send_item(CMD_UNUSED_LO, '1, '1, '1, '1, '1, '1);
        send_item(CMD_UNUSED_HI, '0, '0, '0, '0, '0, '0);
        send_item(ptis_pkg::CMD_PREP, '0, '0, '0, '0, '0, '0);
        // reject a rising cosine
        load_entry(ptis_pkg::ONE_Q30, 32'h0001_0000, 32'd0, 32'd0, 32'd0);
        send_item(ptis_pkg::CMD_PREP, '0, '0, '0, '0, '0, '0);
        load_entry(32'h1000_0000, 32'h0001_0000, 32'd0, 32'd0, 32'd0);
        load_entry(32'h2000_0000, 32'h0001_0000, 32'd0, 32'd0, 32'd0);
        load_entry(ptis_pkg::NEG_ONE_Q30, 32'h0001_0000, 32'd0, 32'd0, 32'd0);
        send_item(ptis_pkg::CMD_PREP, '0, '0, '0, '0, '0, '0);
        // zero integral
        send_item(ptis_pkg::CMD_CLEAR, '0, '0, '0, '0, '0, '0);
        load_entry(ptis_pkg::ONE_Q30, 32'd0, 32'd0, 32'h7fff_ffff, 32'h8000_0000);
        load_entry(ptis_pkg::NEG_ONE_Q30, 32'd0, 32'd0, 32'h8000_0000, 32'h7fff_ffff);
        send_item(ptis_pkg::CMD_PREP, '0, '0, '0, '0, '0, '0);
        // good table with equal neighbours
        send_item(ptis_pkg::CMD_CLEAR, '0, '0, '0, '0, '0, '0);
        load_entry(ptis_pkg::ONE_Q30, 32'h7fff_ffff, 32'h8000_0000, 32'h0003_0000,
                   32'hffff_0000);
        load_entry(32'd0, 32'h0002_0000, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000);
        load_entry(32'd0, 32'h0001_0000, 32'h0000_8000, 32'h0000_0001, 32'h0001_0000);
        load_entry(ptis_pkg::NEG_ONE_Q30, 32'h0004_0000, 32'hfffe_0000, 32'h8000_0000,
                   32'h0000_0000);
        send_item(ptis_pkg::CMD_PREP, '0, '0, '0, '0, '0, '0);
        send_item(ptis_pkg::CMD_QUERY, 32'h7fff_ffff, '0, '0, '0, '0, '0);
        send_item(ptis_pkg::CMD_QUERY, 32'h8000_0000, '0, '0, '0, '0, '0);
        send_item(ptis_pkg::CMD_QUERY, 32'h2000_0000, '0, '0, '0, '0, '0);
        send_item(ptis_pkg::CMD_SAMPLE, '0, '0, '0, '0, '0, 32'h0000_0000);
        send_item(ptis_pkg::CMD_SAMPLE, '0, '0, '0, '0, '0, 32'hffff_ffff);
        send_item(ptis_pkg::CMD_PREP, '0, '0, '0, '0, '0, '0);
        send_item(ptis_pkg::CMD_QUERY, 32'hf000_0000, '0, '0, '0, '0, '0);
        load_entry(ptis_pkg::NEG_ONE_Q30, 32'd0, 32'd0, 32'd0, 32'd0);
        send_item(ptis_pkg::CMD_SAMPLE, '0, '0, '0, '0, '0, 32'h4000_0000);
        wait_idle();
    endtask

    task automatic test_full_table();
        int k;
        no_idle = 1'b1;
        send_item(ptis_pkg::CMD_CLEAR, '0, '0, '0, '0, '0, '0);
        for (k = 0; k < TBL_DEPTH; k++)
            load_entry((k == TBL_DEPTH - 1) ? ptis_pkg::NEG_ONE_Q30
                                            : ptis_pkg::ONE_Q30 - k * 32'd8421504,
                       $urandom_range(0, 32'h0010_0000), $urandom, $urandom, $urandom);
        load_entry(ptis_pkg::NEG_ONE_Q30, '0, '0, '0, '0);
        send_item(ptis_pkg::CMD_PREP, '0, '0, '0, '0, '0, '0);
        no_idle = 1'b0;
        for (k = 0; k < 4; k++) begin
            send_item(ptis_pkg::CMD_QUERY, $urandom, '0, '0, '0, '0, '0);
            send_item(ptis_pkg::CMD_SAMPLE, '0, '0, '0, '0, '0, $urandom);
        end
        wait_idle();
    endtask

    task automatic test_random();
        int n;
        int k;
        int ops;
        int kind;
        longint cur;
        longint span;
        logic [31:0] cv;
        logic [31:0] r1;
        while (items_sent < RAND_ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            send_item(ptis_pkg::CMD_CLEAR, '0, '0, '0, '0, '0, '0);
            n = $urandom_range(2, 8);
            cur = ptis_pkg::ONE_Q30;
            for (k = 0; k < n; k++) begin
                if (k == 0) cv = ptis_pkg::ONE_Q30;
                else if (k == n - 1) cv = ptis_pkg::NEG_ONE_Q30;
                else begin
                    span = cur + ptis_pkg::ONE_Q30;
                    if ($urandom_range(0, 7) != 0)
                        cur = cur - $urandom_range(0, 32'(span / (n - 1 - k)));
                    cv = 32'(cur);
                end
                if ($urandom_range(0, 11) == 0) cv = $urandom;
                r1 = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 32'h0020_0000) : $urandom;
                load_entry(cv, r1, $urandom, $urandom, $urandom);
            end
            send_item(ptis_pkg::CMD_PREP, '0, '0, '0, '0, '0, '0);
            ops = $urandom_range(4, 12);
            for (k = 0; k < ops; k++) begin
                kind = $urandom_range(0, 19);
                if (kind < 8) begin
                    cv = ($urandom_range(0, 4) == 0) ? $urandom
                         : 32'(longint'($urandom_range(0, 32'h8000_0000))
                               - ptis_pkg::ONE_Q30);
                    send_item(ptis_pkg::CMD_QUERY, cv, $urandom, $urandom, $urandom,
                              $urandom, $urandom);
                end else if (kind < 17) begin
                    send_item(ptis_pkg::CMD_SAMPLE, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom);
                end else if (kind == 17) begin
                    send_item(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), $urandom,
                              $urandom, $urandom, $urandom, $urandom, $urandom);
                end else if (kind == 18) begin
                    send_item(ptis_pkg::CMD_PREP, '0, '0, '0, '0, '0, '0);
                end else begin
                    load_entry(ptis_pkg::NEG_ONE_Q30, $urandom_range(0, 32'h0001_0000),
                               $urandom, $urandom, $urandom);
                end
            end
        end
        wait_idle();
    endtask

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ptis_pkg::CMD_CLEAR;
        tbl_count = 0;
        tbl_ready = 1'b0;
        err_count = 0;
        items_sent = 0;
        no_idle = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed();
        test_full_table();
        test_random();
        repeat (50) @(posedge aclk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

@@ phase_table_interp_sampler.f @@
rtl/ptis_pkg.sv
rtl/ptis_div.sv
rtl/ptis_mul.sv
rtl/phase_table_interp_sampler.sv
tb/testbench.sv
